>>> src/bcm_pkg.sv
// ---------------------------------------------------------------------------
// bcm_pkg
// Shared constants for the bubble coalescence merge datapath.
// ---------------------------------------------------------------------------
package bcm_pkg;

    // Cube root consumes three bits of the volume sum per root bit
    localparam int unsigned CBRT_DIGIT = 3;

    // Number of velocity components
    localparam int unsigned NUM_AXES = 3;

    // Cells needed to cover both the cube root and the quotient
    function automatic int unsigned chain_len(input int unsigned rw, input int unsigned vw);
        int unsigned n;
        n = (rw + 1 > vw) ? rw + 1 : vw;
        return n;
    endfunction

endpackage

>>> src/bcm_if.sv
// ---------------------------------------------------------------------------
// bcm_in_if / bcm_out_if
// Valid/ready channels carrying bubble pairs in and merged bubbles out.
// ---------------------------------------------------------------------------
interface bcm_in_if #(
    parameter int unsigned RADIUS_WIDTH   = 16,
    parameter int unsigned VELOCITY_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic        [RADIUS_WIDTH-1:0]   first_radius;
    logic signed [VELOCITY_WIDTH-1:0] first_vel_x;
    logic signed [VELOCITY_WIDTH-1:0] first_vel_y;
    logic signed [VELOCITY_WIDTH-1:0] first_vel_z;
    logic        [RADIUS_WIDTH-1:0]   second_radius;
    logic signed [VELOCITY_WIDTH-1:0] second_vel_x;
    logic signed [VELOCITY_WIDTH-1:0] second_vel_y;
    logic signed [VELOCITY_WIDTH-1:0] second_vel_z;

    modport source (output valid, first_radius, first_vel_x, first_vel_y, first_vel_z,
                    second_radius, second_vel_x, second_vel_y, second_vel_z,
                    input ready);
    modport sink   (input valid, first_radius, first_vel_x, first_vel_y, first_vel_z,
                    second_radius, second_vel_x, second_vel_y, second_vel_z,
                    output ready);
endinterface

interface bcm_out_if #(
    parameter int unsigned RADIUS_WIDTH   = 16,
    parameter int unsigned VELOCITY_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic        [RADIUS_WIDTH-1:0]   merged_radius;
    logic signed [VELOCITY_WIDTH-1:0] merged_vel_x;
    logic signed [VELOCITY_WIDTH-1:0] merged_vel_y;
    logic signed [VELOCITY_WIDTH-1:0] merged_vel_z;
    logic                             radius_saturated;

    modport source (output valid, merged_radius, merged_vel_x, merged_vel_y, merged_vel_z,
                    radius_saturated, input ready);
    modport sink   (input valid, merged_radius, merged_vel_x, merged_vel_y, merged_vel_z,
                    radius_saturated, output ready);
endinterface

>>> src/bcm_front.sv
// ---------------------------------------------------------------------------
// bcm_front
// Front pipeline: volumes, momentum products, signed sums and magnitudes.
// ---------------------------------------------------------------------------
module bcm_front #(
    parameter int unsigned RW = 16,
    parameter int unsigned VW = 16,
    parameter int unsigned TW = 3*RW + 3,
    parameter int unsigned NW = 3*RW + VW + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic [RW-1:0]                  r1,
    input  logic [RW-1:0]                  r2,
    input  logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] v1,
    input  logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] v2,
    output logic                           out_vld,
    output logic [TW-1:0]                  tot,
    output logic [bcm_pkg::NUM_AXES-1:0][NW-1:0] mag,
    output logic [bcm_pkg::NUM_AXES-1:0]   neg,
    output logic                           zero,
    output logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] v1_out
);
    import bcm_pkg::*;

    localparam int unsigned PW = 3*RW + VW + 1;

    logic [3:0] vld_reg;

    // stage 1: squares
    logic [RW-1:0]   r1_a_reg, r2_a_reg;
    logic [2*RW-1:0] sq1_reg, sq2_reg;
    logic [NUM_AXES-1:0][VW-1:0] v1_a_reg, v2_a_reg;
    // stage 2: volumes
    logic [3*RW-1:0] vol1_reg, vol2_reg;
    logic [NUM_AXES-1:0][VW-1:0] v1_b_reg, v2_b_reg;
    // stage 3: products and total volume
    logic [NUM_AXES-1:0][PW-1:0] p1_reg, p2_reg;
    logic [3*RW:0]   tot_c_reg;
    logic [NUM_AXES-1:0][VW-1:0] v1_c_reg;
    // stage 4: signed momentum sums
    logic [NUM_AXES-1:0][PW:0] sum_reg;
    logic [3*RW:0]   tot_d_reg;
    logic [NUM_AXES-1:0][VW-1:0] v1_d_reg;
    // stage 5: magnitude and sign
    logic [TW-1:0]   tot_reg;
    logic [NUM_AXES-1:0][NW-1:0] mag_reg;
    logic [NUM_AXES-1:0] neg_reg;
    logic            zero_reg;
    logic [NUM_AXES-1:0][VW-1:0] v1_e_reg;
    logic            vld_e_reg;

    // valid shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_e_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[2:0], in_vld};
            vld_e_reg <= vld_reg[3];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_a_reg <= r1;
            r2_a_reg <= r2;
            sq1_reg  <= (2*RW)'(r1) * (2*RW)'(r1);
            sq2_reg  <= (2*RW)'(r2) * (2*RW)'(r2);
            v1_a_reg <= v1;
            v2_a_reg <= v2;

            vol1_reg <= (3*RW)'(sq1_reg) * (3*RW)'(r1_a_reg);
            vol2_reg <= (3*RW)'(sq2_reg) * (3*RW)'(r2_a_reg);
            v1_b_reg <= v1_a_reg;
            v2_b_reg <= v2_a_reg;

            for (int j = 0; j < NUM_AXES; j++)
            begin
                p1_reg[j] <= PW'($signed({1'b0, vol1_reg}) * $signed(v1_b_reg[j]));
                p2_reg[j] <= PW'($signed({1'b0, vol2_reg}) * $signed(v2_b_reg[j]));
            end
            tot_c_reg <= {1'b0, vol1_reg} + {1'b0, vol2_reg};
            v1_c_reg  <= v1_b_reg;

            for (int j = 0; j < NUM_AXES; j++)
                sum_reg[j] <= $signed({p1_reg[j][PW-1], p1_reg[j]})
                            + $signed({p2_reg[j][PW-1], p2_reg[j]});
            tot_d_reg <= tot_c_reg;
            v1_d_reg  <= v1_c_reg;

            for (int j = 0; j < NUM_AXES; j++)
            begin
                neg_reg[j] <= sum_reg[j][PW];
                mag_reg[j] <= sum_reg[j][PW] ? NW'(-sum_reg[j]) : NW'(sum_reg[j]);
            end
            tot_reg  <= TW'(tot_d_reg);
            zero_reg <= (tot_d_reg == '0);
            v1_e_reg <= v1_d_reg;
        end
    end

    assign out_vld = vld_e_reg;
    assign tot     = tot_reg;
    assign mag     = mag_reg;
    assign neg     = neg_reg;
    assign zero    = zero_reg;
    assign v1_out  = v1_e_reg;

endmodule

>>> src/bcm_cell.sv
// ---------------------------------------------------------------------------
// bcm_cell
// One chain cell: one cube root digit and one quotient bit per axis.
// ---------------------------------------------------------------------------
module bcm_cell #(
    parameter int unsigned RW = 16,
    parameter int unsigned VW = 16,
    parameter int unsigned TW = 3*RW + 3,
    parameter int unsigned NW = 3*RW + VW + 1,
    parameter int unsigned K  = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           vld_i,
    input  logic [TW-1:0]                  tot_i,
    input  logic [TW-1:0]                  rem_i,
    input  logic [RW:0]                    y_i,
    input  logic [2*RW+1:0]                y2_i,
    input  logic [bcm_pkg::NUM_AXES-1:0][NW-1:0] mag_i,
    input  logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] q_i,
    input  logic [bcm_pkg::NUM_AXES-1:0]   neg_i,
    input  logic                           zero_i,
    input  logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] v1_i,
    output logic                           vld_o,
    output logic [TW-1:0]                  tot_o,
    output logic [TW-1:0]                  rem_o,
    output logic [RW:0]                    y_o,
    output logic [2*RW+1:0]                y2_o,
    output logic [bcm_pkg::NUM_AXES-1:0][NW-1:0] mag_o,
    output logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] q_o,
    output logic [bcm_pkg::NUM_AXES-1:0]   neg_o,
    output logic                           zero_o,
    output logic [bcm_pkg::NUM_AXES-1:0][VW-1:0] v1_o
);
    import bcm_pkg::*;

    localparam int unsigned Y2W = 2*RW + 2;
    localparam int unsigned DW  = NW + VW;

    logic [TW-1:0]  rem_next;
    logic [RW:0]    y_next;
    logic [Y2W-1:0] y2_next;
    logic [NUM_AXES-1:0][NW-1:0] mag_next;
    logic [NUM_AXES-1:0][VW-1:0] q_next;

    // cube root digit: try appending a one bit to the partial root
    generate
        if (K < RW + 1)
        begin : g_root
            localparam int unsigned G = RW - K;
            logic [TW-1:0] rsh;
            logic [TW-1:0] dlt;
            logic          take;
            always_comb
            begin
                rsh  = {rem_i[TW-CBRT_DIGIT-1:0], tot_i[CBRT_DIGIT*G +: CBRT_DIGIT]};
                dlt  = TW'(y2_i) * TW'(12) + TW'(y_i) * TW'(6) + TW'(1);
                take = (rsh >= dlt);
                rem_next = take ? rsh - dlt : rsh;
                y_next   = {y_i[RW-1:0], take};
                y2_next  = {y2_i[Y2W-3:0], 2'b00}
                         + (take ? Y2W'({y_i, 2'b00}) + Y2W'(1) : Y2W'(0));
            end
        end
        else
        begin : g_root_pass
            assign rem_next = rem_i;
            assign y_next   = y_i;
            assign y2_next  = y2_i;
        end
    endgenerate

    // restoring division bit, one lane per axis
    generate
        if (K < VW)
        begin : g_div
            localparam int unsigned B = VW - 1 - K;
            logic [DW-1:0] dsh;
            always_comb
            begin
                dsh = DW'(tot_i) << B;
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    if (DW'(mag_i[j]) >= dsh)
                    begin
                        mag_next[j] = NW'(DW'(mag_i[j]) - dsh);
                        q_next[j]   = q_i[j] | (VW'(1) << B);
                    end
                    else
                    begin
                        mag_next[j] = mag_i[j];
                        q_next[j]   = q_i[j];
                    end
                end
            end
        end
        else
        begin : g_div_pass
            assign mag_next = mag_i;
            assign q_next   = q_i;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_o <= 1'b0;
        else if (en)
            vld_o <= vld_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tot_o  <= tot_i;
            rem_o  <= rem_next;
            y_o    <= y_next;
            y2_o   <= y2_next;
            mag_o  <= mag_next;
            q_o    <= q_next;
            neg_o  <= neg_i;
            zero_o <= zero_i;
            v1_o   <= v1_i;
        end
    end

endmodule

>>> src/bubble_coalescence_merge_top.sv
// ---------------------------------------------------------------------------
// bubble_coalescence_merge_top
// Volume- and momentum-conserving merge of two bubbles.
// ---------------------------------------------------------------------------
// in_ch carries one bubble pair per transaction (radii Q4.12, velocities
// Q8.8 at default widths); out_ch returns the merged radius, the
// volume-weighted mean velocity and a radius saturation flag.
// One transaction is accepted per cycle while out_ch is not blocked. A result
// passes through five front stages for cubes and products, then a chain of
// cells, each resolving one cube root bit and one quotient bit per axis, then
// the output register that drives out_ch.
// The whole pipeline advances together; when out_ch holds a result that is
// not taken, every stage holds and in_ch.ready drops in the same cycle, so
// nothing is lost or repeated. Reset clears all valid flags; the pipeline
// is empty and ready in the first cycle after reset.
// ---------------------------------------------------------------------------
module bubble_coalescence_merge_top #(
    parameter int unsigned RADIUS_WIDTH   = 16,
    parameter int unsigned VELOCITY_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bcm_in_if.sink    in_ch,
    bcm_out_if.source out_ch
);
    import bcm_pkg::*;

    localparam int unsigned RW = RADIUS_WIDTH;
    localparam int unsigned VW = VELOCITY_WIDTH;
    localparam int unsigned TW = 3*RW + 3;
    localparam int unsigned NW = 3*RW + VW + 1;
    localparam int unsigned N  = chain_len(RW, VW);

    logic en;
    logic out_vld_reg;

    // pipeline advances unless a held result is blocked
    assign en          = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en;

    // chain nodes
    logic [N:0]                             c_vld;
    logic [N:0][TW-1:0]                     c_tot;
    logic [N:0][TW-1:0]                     c_rem;
    logic [N:0][RW:0]                       c_y;
    logic [N:0][2*RW+1:0]                   c_y2;
    logic [N:0][NUM_AXES-1:0][NW-1:0]       c_mag;
    logic [N:0][NUM_AXES-1:0][VW-1:0]       c_q;
    logic [N:0][NUM_AXES-1:0]               c_neg;
    logic [N:0]                             c_zero;
    logic [N:0][NUM_AXES-1:0][VW-1:0]       c_v1;

    logic [NUM_AXES-1:0][VW-1:0] v1_in, v2_in;
    assign v1_in = {in_ch.first_vel_z, in_ch.first_vel_y, in_ch.first_vel_x};
    assign v2_in = {in_ch.second_vel_z, in_ch.second_vel_y, in_ch.second_vel_x};

    bcm_front #(.RW(RW), .VW(VW), .TW(TW), .NW(NW)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (in_ch.valid),
        .r1     (in_ch.first_radius),
        .r2     (in_ch.second_radius),
        .v1     (v1_in),
        .v2     (v2_in),
        .out_vld(c_vld[0]),
        .tot    (c_tot[0]),
        .mag    (c_mag[0]),
        .neg    (c_neg[0]),
        .zero   (c_zero[0]),
        .v1_out (c_v1[0])
    );

    // root and quotient start from zero
    assign c_rem[0] = '0;
    assign c_y[0]   = '0;
    assign c_y2[0]  = '0;
    assign c_q[0]   = '0;

    generate
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            bcm_cell #(.RW(RW), .VW(VW), .TW(TW), .NW(NW), .K(k)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .vld_i (c_vld[k]),
                .tot_i (c_tot[k]),
                .rem_i (c_rem[k]),
                .y_i   (c_y[k]),
                .y2_i  (c_y2[k]),
                .mag_i (c_mag[k]),
                .q_i   (c_q[k]),
                .neg_i (c_neg[k]),
                .zero_i(c_zero[k]),
                .v1_i  (c_v1[k]),
                .vld_o (c_vld[k+1]),
                .tot_o (c_tot[k+1]),
                .rem_o (c_rem[k+1]),
                .y_o   (c_y[k+1]),
                .y2_o  (c_y2[k+1]),
                .mag_o (c_mag[k+1]),
                .q_o   (c_q[k+1]),
                .neg_o (c_neg[k+1]),
                .zero_o(c_zero[k+1]),
                .v1_o  (c_v1[k+1])
            );
        end
    endgenerate

    // output register: saturate root, apply sign, zero-volume passthrough
    logic [RW-1:0]               rad_reg;
    logic                        sat_reg;
    logic [NUM_AXES-1:0][VW-1:0] vel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= c_vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= c_y[N][RW];
            rad_reg <= c_y[N][RW] ? {RW{1'b1}} : c_y[N][RW-1:0];
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (c_zero[N])
                    vel_reg[j] <= c_v1[N][j];
                else if (c_neg[N][j])
                    vel_reg[j] <= -c_q[N][j];
                else
                    vel_reg[j] <= c_q[N][j];
            end
        end
    end

    assign out_ch.valid            = out_vld_reg;
    assign out_ch.merged_radius    = rad_reg;
    assign out_ch.radius_saturated = sat_reg;
    assign out_ch.merged_vel_x     = vel_reg[0];
    assign out_ch.merged_vel_y     = vel_reg[1];
    assign out_ch.merged_vel_z     = vel_reg[2];

endmodule

>>> bench/bubble_coalescence_merge_top_tb.sv
// ---------------------------------------------------------------------------
// bubble_coalescence_merge_top_tb
// Self-checking bench for the bubble coalescence merge datapath.
// ---------------------------------------------------------------------------
// A directed table covers zero radii, full-scale radii, saturation and
// velocity extremes; random pairs follow under several idle/stall phases.
// Every merged bubble is compared with an exact integer predictor.
// ---------------------------------------------------------------------------
module bubble_coalescence_merge_top_tb;
    import bcm_pkg::*;

    localparam int unsigned RW = 16;
    localparam int unsigned VW = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [RW-1:0] RAD_MAX = '1;

    typedef struct packed {
        logic [RW-1:0]        r1;
        logic signed [VW-1:0] v1x, v1y, v1z;
        logic [RW-1:0]        r2;
        logic signed [VW-1:0] v2x, v2y, v2z;
    } pair_t;

    typedef struct packed {
        logic [RW-1:0]        radius;
        logic signed [VW-1:0] vx, vy, vz;
        logic                 sat;
    } merged_t;

    // Directed row: typed expectation used only where has_exp is set
    typedef struct packed {
        pair_t   stim;
        logic    has_exp;
        merged_t exp;
    } row_t;

    logic clk;
    logic rst_n;
    bcm_in_if  #(.RADIUS_WIDTH(RW), .VELOCITY_WIDTH(VW)) in_ch ();
    bcm_out_if #(.RADIUS_WIDTH(RW), .VELOCITY_WIDTH(VW)) out_ch ();

    bubble_coalescence_merge_top #(.RADIUS_WIDTH(RW), .VELOCITY_WIDTH(VW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    merged_t pending_merges[$];
    int      error_count;
    int      merges_checked;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    logic    timed_out;

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Exact merge: floor cube root of summed volumes, truncated weighted means
    function automatic merged_t merge_bubbles(pair_t p);
        merged_t m;
        logic [127:0] vol1, vol2, total, cand_cube;
        logic [RW:0] root, cand;
        logic signed [VW-1:0] va[3], vb[3], vo[3];
        logic signed [127:0] num, q;
        vol1 = 128'(p.r1) * p.r1 * p.r1;
        vol2 = 128'(p.r2) * p.r2 * p.r2;
        total = vol1 + vol2;
        root = '0;
        for (int b = RW; b >= 0; b--)
        begin
            cand = root | ((RW+1)'(1) << b);
            cand_cube = 128'(cand) * cand * cand;
            if (total >= cand_cube)
                root = cand;
        end
        if (root > RAD_MAX)
        begin
            m.radius = RAD_MAX;
            m.sat = 1'b1;
        end
        else
        begin
            m.radius = root[RW-1:0];
            m.sat = 1'b0;
        end
        va = '{p.v1x, p.v1y, p.v1z};
        vb = '{p.v2x, p.v2y, p.v2z};
        for (int k = 0; k < 3; k++)
        begin
            if (total == 0)
                vo[k] = va[k];
            else
            begin
                num = $signed(vol1) * va[k] + $signed(vol2) * vb[k];
                // SystemVerilog signed division truncates toward zero
                q = num / $signed(total);
                vo[k] = q[VW-1:0];
            end
        end
        m.vx = vo[0];
        m.vy = vo[1];
        m.vz = vo[2];
        return m;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int sel;
        p = pair_t'({$urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(0, 9);
        // Bias radii toward edges: zero, full scale, small
        if (sel == 0) p.r1 = '0;
        else if (sel == 1) p.r2 = '0;
        else if (sel == 2) p.r1 = RAD_MAX - RW'($urandom_range(0, 3));
        else if (sel == 3) p.r2 = RW'($urandom_range(0, 15));
        else if (sel == 4)
        begin
            p.r1 = '0;
            p.r2 = '0;
        end
        return p;
    endfunction

    // Output checking against the oldest pending merge
    always @(posedge clk)
    begin
        merged_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_merges.size() == 0)
            begin
                $error("unexpected merged bubble: radius %h", out_ch.merged_radius);
                error_count++;
            end
            else
            begin
                e = pending_merges.pop_front();
                merges_checked++;
                if (out_ch.merged_radius !== e.radius)
                begin
                    $error("merged_radius exp %h got %h", e.radius, out_ch.merged_radius);
                    error_count++;
                end
                if (out_ch.merged_vel_x !== e.vx)
                begin
                    $error("merged_vel_x exp %h got %h", e.vx, out_ch.merged_vel_x);
                    error_count++;
                end
                if (out_ch.merged_vel_y !== e.vy)
                begin
                    $error("merged_vel_y exp %h got %h", e.vy, out_ch.merged_vel_y);
                    error_count++;
                end
                if (out_ch.merged_vel_z !== e.vz)
                begin
                    $error("merged_vel_z exp %h got %h", e.vz, out_ch.merged_vel_z);
                    error_count++;
                end
                if (out_ch.radius_saturated !== e.sat)
                begin
                    $error("radius_saturated exp %b got %b", e.sat,
                           out_ch.radius_saturated);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one transaction and wait for its acceptance
    task automatic send_pair(pair_t p, logic has_exp, merged_t exp);
        merged_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.first_radius  <= p.r1;
        in_ch.first_vel_x   <= p.v1x;
        in_ch.first_vel_y   <= p.v1y;
        in_ch.first_vel_z   <= p.v1z;
        in_ch.second_radius <= p.r2;
        in_ch.second_vel_x  <= p.v2x;
        in_ch.second_vel_y  <= p.v2y;
        in_ch.second_vel_z  <= p.v2z;
        pred = merge_bubbles(p);
        if (has_exp && pred !== exp)
        begin
            $error("table row disagrees with predictor: exp %h pred %h", exp, pred);
            error_count++;
        end
        do @(posedge clk); while (!in_ch.ready);
        pending_merges.insert(pending_merges.size(), has_exp ? exp : pred);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_merges.size() != 0)
            @(posedge clk);
    endtask

    row_t directed[] = '{
        // both radii zero: first velocity passes through
        '{'{16'h0000, 16'sh7fff, -16'sh8000, 16'sh0001, 16'h0000, 16'sh1234,
            16'sh0000, -16'sh0001}, 1'b1,
          '{16'h0000, 16'sh7fff, -16'sh8000, 16'sh0001, 1'b0}},
        // one radius zero: other velocity wins
        '{'{16'h0000, 16'sh0100, 16'sh0200, 16'sh0300, 16'h1000, -16'sh8000,
            16'sh7fff, 16'sh0000}, 1'b1,
          '{16'h1000, -16'sh8000, 16'sh7fff, 16'sh0000, 1'b0}},
        '{'{16'h1000, 16'sh0100, 16'sh0200, 16'sh0300, 16'h0000, 16'sh5555,
            16'sh0000, 16'sh0000}, 1'b1,
          '{16'h1000, 16'sh0100, 16'sh0200, 16'sh0300, 1'b0}},
        // full-scale pair saturates the radius
        '{'{16'hffff, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'hffff, 16'sh7fff,
            -16'sh8000, -16'sh8000}, 1'b1,
          '{16'hffff, 16'sh7fff, -16'sh0000, -16'sh8000, 1'b1}},
        '{'{16'hffff, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 16'sh0000,
            16'sh0000, 16'sh0000}, 1'b1,
          '{16'hffff, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0}},
        // remaining rows checked against the predictor
        '{'{16'hffff, 16'sh7fff, -16'sh8000, 16'sh0000, 16'h0001, -16'sh8000,
            16'sh7fff, 16'sh0001}, 1'b0, '0},
        '{'{16'h0001, 16'sh0001, -16'sh0001, 16'sh0003, 16'h0001, -16'sh0002,
            16'sh0002, 16'sh0000}, 1'b0, '0},
        '{'{16'h8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h8000, -16'sh8000,
            -16'sh8000, -16'sh8000}, 1'b0, '0},
        '{'{16'hcb2f, -16'sh0001, 16'sh1000, -16'sh1000, 16'hcb2f, 16'sh0000,
            16'sh0fff, 16'sh1001}, 1'b0, '0},
        '{'{16'haaaa, 16'sh5555, -16'sh5556, 16'sh2aaa, 16'h5555, 16'sh2aaa,
            16'sh5555, -16'sh2aab}, 1'b0, '0}
    };

    initial
    begin
        row_t r;
        error_count = 0;
        merges_checked = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.first_radius, in_ch.first_vel_x, in_ch.first_vel_y, in_ch.first_vel_z,
         in_ch.second_radius, in_ch.second_vel_x, in_ch.second_vel_y,
         in_ch.second_vel_z} = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
        begin
            r = directed[i];
            send_pair(r.stim, r.has_exp, r.exp);
        end
        // hold off until the pipeline has drained
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 30 : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 30 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                send_pair(random_pair(), 1'b0, '0);
        end
        drain();
        repeat (40) @(posedge clk);

        $display("covered %0d merged bubbles: edge radii, saturation, zero volume,",
                 merges_checked);
        $display("velocity extremes, with sender gaps and receiver back-pressure");
        if (error_count == 0 && pending_merges.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
